>>> hdl/oalist_pkg.sv
// Shared types, codes and sizing constants for the ordered array list engine.
package oalist_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W = 32;
	localparam int POS_W = 8;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int GRP = 16;
	localparam int GRP_W = $clog2(GRP);
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
	localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;

	typedef enum logic [1:0] {
		OP_LOCATE = 2'd0,
		OP_GET    = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ILLEGAL   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic              locate;
		logic              ins;
		logic              del;
		logic [CMP_W-1:0]  target;
		logic [CMP_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

>>> hdl/oalist_cell.sv
// One list cell: holds one entry, shifts with its neighbors and flags a hit.
module oalist_cell import oalist_pkg::*; (
	input  logic              clk,
	input  logic [CMP_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] below,
	input  logic [DATA_W-1:0] above,
	output logic [DATA_W-1:0] entry,
	output logic              hit
);

	logic [DATA_W-1:0] entry_q;
	logic              hit_s1;
	logic              live;

	assign live = idx < ctl.count;

	always_ff @(posedge clk) begin
		hit_s1 <= live && (ctl.locate ? (entry_q == ctl.value) : (idx == ctl.target));
		if (ctl.ins && idx > ctl.target) begin
			entry_q <= below;
		end else if (ctl.ins && idx == ctl.target) begin
			entry_q <= ctl.value;
		end else if (ctl.del && idx >= ctl.target) begin
			entry_q <= above;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_s1;

endmodule

>>> hdl/oalist_grp.sv
// Registered first-hit selector over one group of cells.
module oalist_grp import oalist_pkg::*; (
	input  logic                       clk,
	input  logic [GRP-1:0]             hits,
	input  logic [GRP-1:0][DATA_W-1:0] vals,
	output logic                       any,
	output logic [GRP_W-1:0]           off,
	output logic [DATA_W-1:0]          val
);

	logic              any_d;
	logic [GRP_W-1:0]  off_d;
	logic [DATA_W-1:0] val_d;
	logic              any_s2;
	logic [GRP_W-1:0]  off_s2;
	logic [DATA_W-1:0] val_s2;

	always_comb begin
		any_d = |hits;
		off_d = '0;
		val_d = '0;
		for (int k = GRP - 1; k >= 0; k--) begin
			if (hits[k]) begin
				off_d = GRP_W'(k);
				val_d = vals[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s2 <= any_d;
		off_s2 <= off_d;
		val_s2 <= val_d;
	end

	assign any = any_s2;
	assign off = off_s2;
	assign val = val_s2;

endmodule

>>> hdl/ordered_array_list_engine_core.sv
// Top level of the ordered array list engine: request control, cell chain and result port.
//
//  channel | direction | tdata                                    | tuser
//  s_*     | in        | position[7:0], value[39:8]               | operation[1:0]
//  m_*     | out       | found_position[7:0], data_out[39:8],     | status[1:0]
//          |           | length[47:40]                            |
//
// Each request passes through four steps: accept, compare in every cell, first hit per group of
// sixteen cells, then the final group select together with the shift of the cell chain.
// A new request is taken once the previous result has been written to the output register.
// Reset clears the entry count; the cell contents stay undefined until written.
// A stalled output holds the finished request in its last step until the register frees.
module ordered_array_list_engine_core import oalist_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position, value
	input  logic [1:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // found_position, data_out, length
	output logic [1:0]  m_tuser   // status
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PROBE  = 4'b0010,
		S_GROUP  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	op_t                op_q;
	logic [POS_W-1:0]   pos_q;
	logic [DATA_W-1:0]  val_q;
	logic               m_valid_q;
	status_t            m_status_q;
	logic [POS_W-1:0]   m_found_q;
	logic [DATA_W-1:0]  m_data_q;
	logic [POS_W-1:0]   m_len_q;

	cell_ctl_t          ctl;
	logic               fin_fire;
	logic [NGRP*GRP-1:0]             hit_all;
	logic [NGRP*GRP-1:0][DATA_W-1:0] ent_all;
	logic [NGRP-1:0]                 grp_any;
	logic [NGRP-1:0][GRP_W-1:0]      grp_off;
	logic [NGRP-1:0][DATA_W-1:0]     grp_val;

	logic [GIDX_W-1:0]  sel_g;
	logic               sel_any;
	logic [GRP_W-1:0]   sel_off;
	logic [DATA_W-1:0]  sel_val;
	logic [CMP_W-1:0]   sel_idx;
	logic [CMP_W-1:0]   pos_w;
	logic [CMP_W-1:0]   cnt_w;
	logic               legal_rd;
	logic               legal_ins;
	logic               full;
	status_t            res_status;
	logic [POS_W-1:0]   res_found;
	logic [DATA_W-1:0]  res_data;
	logic [CNT_W-1:0]   nxt_cnt;
	logic               do_ins;
	logic               do_del;

	assign s_tready = (state_q == S_IDLE);
	assign fin_fire = (state_q == S_FINISH) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_PROBE;
				end
				S_PROBE:  state_q <= S_GROUP;
				S_GROUP:  state_q <= S_FINISH;
				S_FINISH: begin
					if (fin_fire) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
			if (fin_fire) begin
				cnt_q     <= nxt_cnt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= op_t'(s_tuser);
			pos_q <= s_tdata[7:0];
			val_q <= s_tdata[39:8];
		end
		if (fin_fire) begin
			m_status_q <= res_status;
			m_found_q  <= res_found;
			m_data_q   <= res_data;
			m_len_q    <= POS_W'(nxt_cnt);
		end
	end

	assign pos_w = CMP_W'(pos_q);
	assign cnt_w = CMP_W'(cnt_q);

	assign ctl.locate = (op_q == OP_LOCATE);
	assign ctl.ins    = fin_fire && do_ins;
	assign ctl.del    = fin_fire && do_del;
	assign ctl.target = pos_w - CMP_W'(1);
	assign ctl.count  = cnt_w;
	assign ctl.value  = val_q;

	for (genvar i = 0; i < NGRP * GRP; i++) begin : g_cell
		if (i < CAPACITY) begin : g_real
			logic [DATA_W-1:0] below;
			logic [DATA_W-1:0] above;
			if (i == 0) begin : g_first
				assign below = val_q;
			end else begin : g_mid
				assign below = ent_all[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign above = ent_all[i];
			end else begin : g_inner
				assign above = ent_all[i+1];
			end
			oalist_cell u_cell (
				.clk   (clk),
				.idx   (CMP_W'(i)),
				.ctl   (ctl),
				.below (below),
				.above (above),
				.entry (ent_all[i]),
				.hit   (hit_all[i])
			);
		end else begin : g_pad
			assign ent_all[i] = '0;
			assign hit_all[i] = 1'b0;
		end
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		oalist_grp u_grp (
			.clk  (clk),
			.hits (hit_all[g*GRP +: GRP]),
			.vals (ent_all[g*GRP +: GRP]),
			.any  (grp_any[g]),
			.off  (grp_off[g]),
			.val  (grp_val[g])
		);
	end

	always_comb begin
		sel_any = |grp_any;
		sel_g   = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any[g]) sel_g = GIDX_W'(g);
		end
		sel_off = grp_off[sel_g];
		sel_val = grp_val[sel_g];
		sel_idx = (CMP_W'(sel_g) << GRP_W) | CMP_W'(sel_off);
	end

	assign legal_rd  = (pos_w != '0) && (pos_w <= cnt_w);
	assign legal_ins = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
	assign full      = (cnt_w == CMP_W'(CAPACITY));

	always_comb begin
		res_status = ST_OK;
		res_found  = '0;
		res_data   = '0;
		nxt_cnt    = cnt_q;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		case (op_q)
			OP_LOCATE: begin
				if (sel_any) begin
					res_found = POS_W'(sel_idx + CMP_W'(1));
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			OP_GET: begin
				if (legal_rd) begin
					res_data = sel_val;
				end else begin
					res_status = ST_ILLEGAL;
				end
			end
			OP_INSERT: begin
				if (!legal_ins) begin
					res_status = ST_ILLEGAL;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					nxt_cnt = cnt_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (legal_rd) begin
					res_data = sel_val;
					do_del   = 1'b1;
					nxt_cnt  = cnt_q - CNT_W'(1);
				end else begin
					res_status = ST_ILLEGAL;
				end
			end
			default: res_status = ST_ILLEGAL;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {m_len_q, m_data_q, m_found_q};

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(fin_fire))
		else $error("entry count changed without a finished request");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && res_status == ST_FULL) |-> (cnt_q == CNT_W'(CAPACITY)))
		else $error("full status with room left in the list");

endmodule

>>> bench/ordered_array_list_engine_core_tb.sv
// Testbench for the ordered array list engine core, checked against a shadow list.
`timescale 1ns / 1ps

module ordered_array_list_engine_core_tb;
	import oalist_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		status_t     status;
		logic [7:0]  found_pos;
		logic [31:0] data;
		logic [7:0]  len;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [31:0]  list_shadow [CAPACITY];
	int           list_len = 0;
	list_result_t pending_results [$];
	int           fail_count = 0;
	int           cycle_count = 0;
	int           sender_idle_pct = 0;
	int           receiver_stall_pct = 0;
	logic         hold_active = 1'b0;
	event         hold_off_go;

	ordered_array_list_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ordered_array_list_engine_core_tb failed");
			$finish;
		end
	end

	// Applies one request to the shadow list and returns the result the block must give.
	function automatic list_result_t predict_list_op(op_t op, logic [7:0] pos, logic [31:0] val);
		list_result_t r;
		int p;
		r = '{ST_OK, 8'd0, 32'd0, 8'd0};
		p = pos;
		case (op)
		OP_LOCATE: begin
			r.status = ST_NOT_FOUND;
			for (int k = 0; k < list_len; k++) begin
				if (r.status == ST_NOT_FOUND && list_shadow[k] == val) begin
					r.status = ST_OK;
					r.found_pos = 8'(k + 1);
				end
			end
		end
		OP_GET: begin
			if (p >= 1 && p <= list_len)
				r.data = list_shadow[p - 1];
			else
				r.status = ST_ILLEGAL;
		end
		OP_INSERT: begin
			if (p < 1 || p > list_len + 1) begin
				r.status = ST_ILLEGAL;
			end else if (list_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				for (int k = list_len; k >= p; k--)
					list_shadow[k] = list_shadow[k - 1];
				list_shadow[p - 1] = val;
				list_len++;
			end
		end
		default: begin
			if (p >= 1 && p <= list_len) begin
				r.data = list_shadow[p - 1];
				for (int k = p; k < list_len; k++)
					list_shadow[k - 1] = list_shadow[k];
				list_len--;
			end else begin
				r.status = ST_ILLEGAL;
			end
		end
		endcase
		r.len = 8'(list_len);
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] corner [6];
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
			32'h8000_0000, 32'd100};
		case ($urandom_range(3))
		0: return corner[$urandom_range(5)];
		1: return 32'($urandom_range(15));
		default: return $urandom;
		endcase
	endfunction

	// Offers one request, with random idle cycles before it, and waits until it is taken.
	task automatic send_request(input op_t op, input logic [7:0] pos, input logic [31:0] val);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {val, pos};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(predict_list_op(op, pos, val));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly legal requests against the current list, with some noise of any shape.
	task automatic send_random_request(input int insert_w, input int delete_w);
		op_t op;
		logic [7:0] pos;
		logic [31:0] val;
		int roll;
		val = pick_value();
		if ($urandom_range(99) < 8) begin
			op = op_t'($urandom_range(3));
			pos = 8'($urandom_range(255));
			val = $urandom;
		end else begin
			roll = $urandom_range(40 + insert_w + delete_w - 1);
			if (roll < 20)
				op = OP_LOCATE;
			else if (roll < 40)
				op = OP_GET;
			else if (roll < 40 + insert_w)
				op = OP_INSERT;
			else
				op = OP_DELETE;
			if (op == OP_INSERT)
				pos = 8'($urandom_range(list_len + 1, 1));
			else if (list_len > 0)
				pos = 8'($urandom_range(list_len, 1));
			else
				pos = 8'd1;
			if (op == OP_LOCATE && list_len > 0 && $urandom_range(1))
				val = list_shadow[$urandom_range(list_len - 1)];
		end
		send_request(op, pos, val);
	endtask

	task automatic test_empty_and_edges();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_request(OP_LOCATE, 8'd0, 32'h0000_0000);
		send_request(OP_GET, 8'd1, 32'h0);
		send_request(OP_DELETE, 8'd1, 32'h0);
		send_request(OP_INSERT, 8'd0, 32'h1234_5678);
		send_request(OP_INSERT, 8'd2, 32'h1234_5678);
		send_request(OP_INSERT, 8'd1, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 8'd1, 32'h8000_0000);
		send_request(OP_INSERT, 8'd3, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 8'd2, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 8'd5, 32'h0000_0000);
		send_request(OP_LOCATE, 8'd255, 32'hFFFF_FFFF);
		send_request(OP_LOCATE, 8'd0, 32'h8000_0000);
		send_request(OP_LOCATE, 8'd0, 32'h0000_0000);
		send_request(OP_LOCATE, 8'd0, 32'h5555_AAAA);
		send_request(OP_GET, 8'd1, 32'hFFFF_FFFF);
		send_request(OP_GET, 8'd5, 32'h0);
		send_request(OP_GET, 8'd6, 32'h0);
		send_request(OP_GET, 8'd255, 32'h0);
		send_request(OP_DELETE, 8'd255, 32'h0);
		send_request(OP_DELETE, 8'd5, 32'h0);
		send_request(OP_DELETE, 8'd1, 32'h0);
		send_request(OP_LOCATE, 8'd0, 32'h8000_0000);
		send_request(OP_DELETE, 8'd0, 32'h0);
		wait_results_drained();
	endtask

	task automatic test_full_list();
		sender_idle_pct = 15;
		receiver_stall_pct = 15;
		while (list_len < CAPACITY)
			send_request(OP_INSERT, 8'($urandom_range(list_len + 1, 1)), pick_value());
		send_request(OP_INSERT, 8'(CAPACITY + 1), $urandom);
		send_request(OP_INSERT, 8'd1, $urandom);
		send_request(OP_INSERT, 8'(CAPACITY + 2), $urandom);
		send_request(OP_INSERT, 8'd0, $urandom);
		send_request(OP_GET, 8'(CAPACITY), 32'h0);
		send_request(OP_GET, 8'(CAPACITY + 1), 32'h0);
		send_request(OP_LOCATE, 8'd0, list_shadow[CAPACITY - 1]);
		send_request(OP_DELETE, 8'(CAPACITY), 32'h0);
		send_request(OP_INSERT, 8'(CAPACITY), 32'h8000_0000);
		send_request(OP_INSERT, 8'(CAPACITY), 32'h7FFF_FFFF);
		while (list_len > 0)
			send_request(OP_DELETE, 8'($urandom_range(list_len, 1)), $urandom);
		send_request(OP_DELETE, 8'd1, 32'h0);
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		int insert_w;
		int delete_w;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		insert_w = 30;
		delete_w = 30;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(2))
				0: begin insert_w = 55; delete_w = 10; end
				1: begin insert_w = 10; delete_w = 55; end
				default: begin insert_w = 30; delete_w = 30; end
				endcase
			end
			send_random_request(insert_w, delete_w);
		end
		wait_results_drained();
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_output_hold();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		-> hold_off_go;
		for (int n = 0; n < 30; n++)
			send_random_request(40, 20);
		wait_results_drained();
	endtask

	always begin
		@(hold_off_go);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_active)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin : check_result
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.found_pos = m_tdata[7:0];
			got.data = m_tdata[39:8];
			got.len = m_tdata[47:40];
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result status=%0d found=%0d data=%h length=%0d",
					$time, got.status, got.found_pos, got.data, got.len);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					$display("%0t: expected status=%0d found=%0d data=%h length=%0d",
						$time, want.status, want.found_pos, want.data, want.len);
					$display("%0t: actual   status=%0d found=%0d data=%h length=%0d",
						$time, got.status, got.found_pos, got.data, got.len);
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < CAPACITY; k++)
			list_shadow[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_and_edges();
		test_full_list();
		test_random_traffic(300, 0, 0);
		test_output_hold();
		test_random_traffic(300, 66, 0);
		test_random_traffic(300, 0, 66);
		test_random_traffic(300, 15, 15);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("ordered_array_list_engine_core_tb passed");
		end else begin
			$display("ordered_array_list_engine_core_tb failed");
		end
		$finish;
	end

endmodule
